/* hdl/qta_pkg.sv */
// Shared constants, widths and register codes for the quantized tanh block.
`timescale 1ns / 1ps
package qta_pkg;

  // Number format of the sample and the result
  localparam int FRAC_BITS   = 16;
  localparam int IN_BITS     = 32;
  localparam int OUT_BITS    = 18;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANT_BITS = 2'd0,
    CFG_ROUND_MODE = 2'd1
  } cfg_idx_t;

  // Datapath widths
  localparam int MAG_W = IN_BITS + 1;           // magnitude plus rounding carry
  localparam int A1_W  = FRAC_BITS + 2;         // holds 2.0
  localparam int A2_W  = FRAC_BITS + 3;         // holds 4.0
  localparam int W1_W  = 2 * FRAC_BITS + 3;     // a1*(4 - a1), at most 2^(2F+2)
  localparam int W2_W  = 2 * FRAC_BITS + 5;     // a2*(8 - a2), at most 2^(2F+4)
  localparam int SUM_W = 2 * FRAC_BITS + 9;     // w1<<6 plus w2
  localparam int Q_W   = $clog2(FRAC_BITS + 1); // saturated fraction bit count
  localparam int SH_W  = $clog2(SUM_W);         // right shifts up to 2F+8

endpackage

/* hdl/qta_poly.sv */
// Quadratic terms: w1 = a1*(4 - a1) and w2 = a2*(8 - a2), both in fixed point.
`timescale 1ns / 1ps
module qta_poly (
  input  logic [qta_pkg::A1_W-1:0] a1,
  input  logic [qta_pkg::A2_W-1:0] a2,
  output logic [qta_pkg::W1_W-1:0] w1,
  output logic [qta_pkg::W2_W-1:0] w2
);

  logic [2*qta_pkg::A1_W-1:0] sq1;
  logic [2*qta_pkg::A2_W-1:0] sq2;
  logic [2*qta_pkg::A1_W-1:0] lin1;
  logic [2*qta_pkg::A2_W-1:0] lin2;
  logic [2*qta_pkg::A1_W-1:0] dif1;
  logic [2*qta_pkg::A2_W-1:0] dif2;

  assign sq1  = a1 * a1;
  assign sq2  = a2 * a2;
  // 4 and 8 scaled by 2^F: a1 << (F+2), a2 << (F+3)
  assign lin1 = {a1, (qta_pkg::A1_W)'(0)} >> (qta_pkg::A1_W - qta_pkg::FRAC_BITS - 2);
  assign lin2 = {a2, (qta_pkg::A2_W)'(0)} >> (qta_pkg::A2_W - qta_pkg::FRAC_BITS - 3);
  assign dif1 = lin1 - sq1;
  assign dif2 = lin2 - sq2;
  assign w1   = dif1[qta_pkg::W1_W-1:0];
  assign w2   = dif2[qta_pkg::W2_W-1:0];

endmodule

/* hdl/quantized_tanh_approx.sv */
// Top level of the piecewise-quadratic tanh activation with optional quantization.
`timescale 1ns / 1ps
// Piecewise-quadratic tanh activation, one sample per item, no state between
// items. Each item goes through four registers: the input register, a
// magnitude stage (sign split, optional quantization of the magnitude, clips
// at 2 and 4), a product stage (the two squarers) and the result register,
// which also does the per-term rounding, the sum and the sign restore.
// out_tvalid rises once an accepted item has reached the result register,
// after the magnitude and product registers. One item per clock
// is sustained: every stage moves whenever the stage after it is empty or
// moving, so in_tready stays high while out_tready is high.
// Stalls ripple back combinationally from out_tready to in_tready.
// Configuration: index 0 is quant_bits (6-bit signed; negative disables
// quantization, values above the fraction width saturate), index 1 is
// round_mode (0 floor, 1 round half up). cfg_ready is always high; write only
// while no item is in flight. Reset gives quant_bits = -1, round_mode = 0.
module quantized_tanh_approx (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [qta_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] x_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [qta_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [17:0] y_value, rest zero
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qta_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int F = qta_pkg::FRAC_BITS;

  // Configuration registers
  logic [qta_pkg::CFG_DATA_W-1:0] qbits_r;
  logic                           round_r;

  // Pipeline registers
  logic                          v_in_r, v_cl_r, v_pr_r, out_valid_r;
  logic [qta_pkg::IN_BITS-1:0]   x_r;
  logic                          neg_cl_r, neg_pr_r;
  logic [qta_pkg::A1_W-1:0]      a1_r;
  logic [qta_pkg::A2_W-1:0]      a2_r;
  logic [qta_pkg::W1_W-1:0]      w1_r;
  logic [qta_pkg::W2_W-1:0]      w2_r;
  logic [qta_pkg::OUT_BITS-1:0]  y_r;

  // Handshake
  logic in_acc, ld_cl, ld_pr, ld_out;

  assign ld_out    = v_pr_r && (!out_valid_r || out_tready);
  assign ld_pr     = v_cl_r && (!v_pr_r || ld_out);
  assign ld_cl     = v_in_r && (!v_cl_r || ld_pr);
  assign in_tready = !v_in_r || ld_cl;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Quantization settings; the user must hold them steady while items are in flight (not enforced here)
  logic                   quant_en;
  logic [qta_pkg::Q_W-1:0] q;
  logic [qta_pkg::Q_W-1:0] s;
  logic                   hu;

  assign quant_en = !qbits_r[qta_pkg::CFG_DATA_W-1];
  assign hu       = round_r;
  always_comb begin
    if ($signed(qbits_r) > $signed((qta_pkg::CFG_DATA_W)'(F)))
      q = (qta_pkg::Q_W)'(F);
    else
      q = qbits_r[qta_pkg::Q_W-1:0];
  end
  assign s = (qta_pkg::Q_W)'(F) - q;

  // Magnitude stage
  logic [qta_pkg::IN_BITS-1:0] mag;
  logic [qta_pkg::MAG_W-1:0]   half_m, mag_rnd, mag_mask, mag_sel;
  logic [qta_pkg::A1_W-1:0]    a1_nxt;
  logic [qta_pkg::A2_W-1:0]    a2_nxt;
  localparam logic [qta_pkg::MAG_W-1:0] TWO  = (qta_pkg::MAG_W)'(2) << F;
  localparam logic [qta_pkg::MAG_W-1:0] FOUR = (qta_pkg::MAG_W)'(4) << F;

  // most negative sample negates onto itself, read as unsigned 2^(IN-1)
  assign mag      = x_r[qta_pkg::IN_BITS-1] ? (~x_r + 1'b1) : x_r;
  assign half_m   = (hu && (s != '0)) ? ((qta_pkg::MAG_W)'(1) << (s - 1'b1)) : '0;
  assign mag_rnd  = {1'b0, mag} + half_m;
  assign mag_mask = ~(((qta_pkg::MAG_W)'(1) << s) - 1'b1);
  assign mag_sel  = quant_en ? (mag_rnd & mag_mask) : {1'b0, mag};
  assign a1_nxt   = (mag_sel > TWO)  ? TWO[qta_pkg::A1_W-1:0]  : mag_sel[qta_pkg::A1_W-1:0];
  assign a2_nxt   = (mag_sel > FOUR) ? FOUR[qta_pkg::A2_W-1:0] : mag_sel[qta_pkg::A2_W-1:0];

  // Product stage
  logic [qta_pkg::W1_W-1:0] w1_nxt;
  logic [qta_pkg::W2_W-1:0] w2_nxt;

  qta_poly u_poly (
    .a1 (a1_r),
    .a2 (a2_r),
    .w1 (w1_nxt),
    .w2 (w2_nxt)
  );

  // Result stage: y1 is scaled by 2^(2F+2), y2 by 2^(2F+8)
  logic [qta_pkg::SH_W-1:0]     sh1, sh2;
  logic [qta_pkg::SUM_W-1:0]    rnd1, rnd2, r1, r2, yq, yn, ysel;
  logic [qta_pkg::OUT_BITS-1:0] y_mag, y_nxt;

  assign sh1  = (qta_pkg::SH_W)'(2 * F + 2) - (qta_pkg::SH_W)'(q);
  assign sh2  = (qta_pkg::SH_W)'(2 * F + 8) - (qta_pkg::SH_W)'(q);
  assign rnd1 = hu ? ((qta_pkg::SUM_W)'(1) << (sh1 - 1'b1)) : '0;
  assign rnd2 = hu ? ((qta_pkg::SUM_W)'(1) << (sh2 - 1'b1)) : '0;
  assign r1   = ((qta_pkg::SUM_W)'(w1_r) + rnd1) >> sh1;
  assign r2   = ((qta_pkg::SUM_W)'(w2_r) + rnd2) >> sh2;
  assign yq   = (r1 + r2) << s;
  // unquantized: exact sum floored to F fraction bits
  assign yn   = (((qta_pkg::SUM_W)'(w1_r) << 6) + (qta_pkg::SUM_W)'(w2_r)) >> (F + 8);
  assign ysel  = quant_en ? yq : yn;
  assign y_mag = ysel[qta_pkg::OUT_BITS-1:0];
  assign y_nxt = neg_pr_r ? (~y_mag + 1'b1) : y_mag;

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qbits_r     <= '1;
      round_r     <= 1'b0;
      v_in_r      <= 1'b0;
      v_cl_r      <= 1'b0;
      v_pr_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          qta_pkg::CFG_QUANT_BITS: qbits_r <= cfg_data;
          qta_pkg::CFG_ROUND_MODE: round_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_acc)     v_in_r <= 1'b1;
      else if (ld_cl) v_in_r <= 1'b0;
      if (ld_cl)      v_cl_r <= 1'b1;
      else if (ld_pr) v_cl_r <= 1'b0;
      if (ld_pr)       v_pr_r <= 1'b1;
      else if (ld_out) v_pr_r <= 1'b0;
      if (ld_out)          out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) x_r <= in_tdata[qta_pkg::IN_BITS-1:0];
    if (ld_cl) begin
      neg_cl_r <= x_r[qta_pkg::IN_BITS-1];
      a1_r     <= a1_nxt;
      a2_r     <= a2_nxt;
    end
    if (ld_pr) begin
      neg_pr_r <= neg_cl_r;
      w1_r     <= w1_nxt;
      w2_r     <= w2_nxt;
    end
    if (ld_out) y_r <= y_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = (qta_pkg::OUT_TDATA_W)'(y_r);

`ifndef SYNTHESIS
  // an item leaving the magnitude stage always lands in the product stage
  a_cl_to_pr: assert property (@(posedge clk) disable iff (!rst_n)
    ld_pr |=> v_pr_r)
    else $error("product stage lost an item");

  // clipped magnitudes stay within 2 and 4, and a1 never exceeds a2
  a_clip: assert property (@(posedge clk) disable iff (!rst_n)
    v_cl_r |-> ((a1_r <= TWO[qta_pkg::A1_W-1:0]) && (a2_r <= FOUR[qta_pkg::A2_W-1:0])
                && ((qta_pkg::A2_W)'(a1_r) <= a2_r)))
    else $error("clipped magnitude out of range");

  // a full, stalled pipeline must refuse new items
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_in_r && v_cl_r && v_pr_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline full");

  // a taken result with nothing behind it empties the result register
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !v_pr_r) |=> !out_valid_r)
    else $error("result repeated");
`endif

endmodule
